// ----- sv/pfa_pkg.sv -----
package pfa_pkg;

    localparam int FRAME_W = 11;
    localparam int OWNER_W = 8;
    localparam int PAGE_W  = 11;

    // command kinds decided by the front end
    localparam logic [2:0] K_NOP     = 3'd0;
    localparam logic [2:0] K_ALLOC   = 3'd1;
    localparam logic [2:0] K_NOUSER  = 3'd2;
    localparam logic [2:0] K_READ    = 3'd3;
    localparam logic [2:0] K_WRITE   = 3'd4;
    localparam logic [2:0] K_KERNEL  = 3'd5;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    typedef struct packed {
        logic [2:0]         kind;
        logic [OWNER_W-1:0] owner;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] fidx;
    } pfa_cmd_t;

endpackage

// ----- sv/page_frame_allocator_clock_core.sv -----
// Frame table with clock replacement. A front end classifies each request and
// queues it two deep; the back end executes it against per-frame memories.
// Accesses and allocations that find a free frame complete in the idle state
// (free frames are tracked by a fill count, as frames are never released).
// An eviction is dispatched from the idle state and then sweeps the clock hand,
// taking a read state and a check state per frame examined, set by the
// registered read of the referenced-bit memory; a set referenced bit is
// cleared as a second chance. No clearing pass is needed after reset.
module page_frame_allocator_clock_core #(
    parameter int NUM_FRAMES       = 2048,
    parameter int FIRST_USER_FRAME = 256,
    parameter int OWNER_BITS       = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              operation,
    input  logic [pfa_pkg::OWNER_W-1:0] owner_id,
    input  logic [pfa_pkg::PAGE_W-1:0]  page_number,
    input  logic [pfa_pkg::FRAME_W-1:0] frame_index,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [pfa_pkg::FRAME_W-1:0] frame,
    output logic                    evicted,
    output logic                    writeback_needed,
    output logic [pfa_pkg::OWNER_W-1:0] victim_owner,
    output logic [pfa_pkg::PAGE_W-1:0]  victim_page,
    output logic                    status
);
    import pfa_pkg::*;

    pfa_cmd_t cmd;
    logic     cmd_valid, cmd_pop;

    pfa_front #(
        .NUM_FRAMES       (NUM_FRAMES),
        .FIRST_USER_FRAME (FIRST_USER_FRAME)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .owner_id    (owner_id),
        .page_number (page_number),
        .frame_index (frame_index),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .cmd         (cmd)
    );

    pfa_back #(
        .NUM_FRAMES       (NUM_FRAMES),
        .FIRST_USER_FRAME (FIRST_USER_FRAME),
        .OWNER_BITS       (OWNER_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd_valid        (cmd_valid),
        .cmd_pop          (cmd_pop),
        .cmd              (cmd),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .frame            (frame),
        .evicted          (evicted),
        .writeback_needed (writeback_needed),
        .victim_owner     (victim_owner),
        .victim_page      (victim_page),
        .status           (status)
    );

endmodule

// ----- sv/pfa_front.sv -----
module pfa_front #(
    parameter int NUM_FRAMES       = 2048,
    parameter int FIRST_USER_FRAME = 256
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              operation,
    input  logic [pfa_pkg::OWNER_W-1:0] owner_id,
    input  logic [pfa_pkg::PAGE_W-1:0]  page_number,
    input  logic [pfa_pkg::FRAME_W-1:0] frame_index,
    output logic                    cmd_valid,
    input  logic                    cmd_pop,
    output pfa_pkg::pfa_cmd_t       cmd
);
    import pfa_pkg::*;

    pfa_cmd_t   q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    pfa_cmd_t   cls;
    logic       in_range;
    logic       push;

    always_comb
    begin
        in_range = (32'(frame_index) >= 32'(FIRST_USER_FRAME))
                && (32'(frame_index) < 32'(NUM_FRAMES));
        cls.owner = owner_id;
        cls.page  = page_number;
        cls.fidx  = frame_index;
        case (operation)
            OP_ALLOC: cls.kind = (FIRST_USER_FRAME >= NUM_FRAMES) ? K_NOUSER : K_ALLOC;
            OP_READ:  cls.kind = in_range ? K_READ : K_KERNEL;
            OP_WRITE: cls.kind = in_range ? K_WRITE : K_KERNEL;
            default:  cls.kind = K_NOP;
        endcase
    end

    assign in_ready  = (count_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(cmd_pop);
        end
    end

endmodule

// ----- sv/pfa_back.sv -----
module pfa_back #(
    parameter int NUM_FRAMES       = 2048,
    parameter int FIRST_USER_FRAME = 256,
    parameter int OWNER_BITS       = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    output logic                    cmd_pop,
    input  pfa_pkg::pfa_cmd_t       cmd,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [pfa_pkg::FRAME_W-1:0] frame,
    output logic                    evicted,
    output logic                    writeback_needed,
    output logic [pfa_pkg::OWNER_W-1:0] victim_owner,
    output logic [pfa_pkg::PAGE_W-1:0]  victim_page,
    output logic                    status
);
    import pfa_pkg::*;

    localparam int FW   = $clog2(NUM_FRAMES);
    localparam int SPAN = (FIRST_USER_FRAME < NUM_FRAMES) ? NUM_FRAMES - FIRST_USER_FRAME : 0;
    localparam int MW   = OWNER_BITS + PAGE_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_CHK  = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [FW-1:0] hand_reg, hand_next;
    logic [FW:0]   fill_reg, fill_next;
    logic [OWNER_BITS-1:0] own_reg, own_next;
    logic [PAGE_W-1:0]     page_reg, page_next;

    logic          ovalid_reg, ovalid_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic          ev_reg, ev_next, wb_reg, wb_next, st_reg, st_next;
    logic [OWNER_W-1:0] vown_reg, vown_next;
    logic [PAGE_W-1:0]  vpage_reg, vpage_next;

    logic          ref_mem [NUM_FRAMES];
    logic          dirty_mem [NUM_FRAMES];
    logic [MW-1:0] meta_mem [NUM_FRAMES];
    logic          ref_rd, dirty_rd;
    logic [MW-1:0] meta_rd;

    logic          ref_we, dirty_we, meta_we;
    logic          ref_wd, dirty_wd;
    logic [FW-1:0] waddr;
    logic [MW-1:0] meta_wd;
    logic [FW-1:0] hand_adv, fresh;

    always_ff @(posedge clk)
    begin
        if (ref_we)
        begin
            ref_mem[waddr] <= ref_wd;
        end
        if (dirty_we)
        begin
            dirty_mem[waddr] <= dirty_wd;
        end
        if (meta_we)
        begin
            meta_mem[waddr] <= meta_wd;
        end
        ref_rd   <= ref_mem[hand_reg];
        dirty_rd <= dirty_mem[hand_reg];
        meta_rd  <= meta_mem[hand_reg];
    end

    always_comb
    begin
        hand_adv = (hand_reg == FW'(NUM_FRAMES - 1)) ? FW'(FIRST_USER_FRAME) : hand_reg + 1'b1;
        fresh    = FW'(32'(FIRST_USER_FRAME) + 32'(fill_reg));

        state_next  = state_reg;
        hand_next   = hand_reg;
        fill_next   = fill_reg;
        own_next    = own_reg;
        page_next   = page_reg;
        ovalid_next = ovalid_reg && !out_ready;
        frame_next  = frame_reg;
        ev_next     = ev_reg;
        wb_next     = wb_reg;
        st_next     = st_reg;
        vown_next   = vown_reg;
        vpage_next  = vpage_reg;
        cmd_pop     = 1'b0;
        ref_we      = 1'b0;
        dirty_we    = 1'b0;
        meta_we     = 1'b0;
        ref_wd      = 1'b0;
        dirty_wd    = 1'b0;
        waddr       = FW'(cmd.fidx);
        meta_wd     = {OWNER_BITS'(cmd.owner), cmd.page};

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && !ovalid_next)
                begin
                    cmd_pop    = 1'b1;
                    frame_next = '0;
                    ev_next    = 1'b0;
                    wb_next    = 1'b0;
                    st_next    = 1'b0;
                    vown_next  = '0;
                    vpage_next = '0;
                    case (cmd.kind)
                        K_ALLOC:
                        begin
                            if (fill_reg != (FW+1)'(SPAN))
                            begin
                                // frames are never freed, so used frames are a prefix
                                waddr       = fresh;
                                meta_we     = 1'b1;
                                ref_we      = 1'b1;
                                dirty_we    = 1'b1;
                                fill_next   = fill_reg + 1'b1;
                                frame_next  = FRAME_W'(fresh);
                                ovalid_next = 1'b1;
                            end
                            else
                            begin
                                own_next   = OWNER_BITS'(cmd.owner);
                                page_next  = cmd.page;
                                state_next = S_RD;
                            end
                        end
                        K_READ, K_WRITE:
                        begin
                            ref_we      = 1'b1;
                            ref_wd      = 1'b1;
                            dirty_we    = (cmd.kind == K_WRITE);
                            dirty_wd    = 1'b1;
                            frame_next  = cmd.fidx;
                            ovalid_next = 1'b1;
                        end
                        K_KERNEL:
                        begin
                            frame_next  = cmd.fidx;
                            st_next     = 1'b1;
                            ovalid_next = 1'b1;
                        end
                        K_NOUSER:
                        begin
                            st_next     = 1'b1;
                            ovalid_next = 1'b1;
                        end
                        default:
                        begin
                            ovalid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                waddr     = hand_reg;
                hand_next = hand_adv;
                ref_we    = 1'b1;
                if (ref_rd)
                begin
                    // second chance
                    state_next = S_RD;
                end
                else
                begin
                    dirty_we    = 1'b1;
                    meta_we     = 1'b1;
                    meta_wd     = {own_reg, page_reg};
                    frame_next  = FRAME_W'(hand_reg);
                    ev_next     = 1'b1;
                    wb_next     = dirty_rd;
                    vown_next   = OWNER_W'(meta_rd[MW-1:PAGE_W]);
                    vpage_next  = meta_rd[PAGE_W-1:0];
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        own_reg   <= own_next;
        page_reg  <= page_next;
        frame_reg <= frame_next;
        ev_reg    <= ev_next;
        wb_reg    <= wb_next;
        st_reg    <= st_next;
        vown_reg  <= vown_next;
        vpage_reg <= vpage_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            hand_reg   <= FW'(FIRST_USER_FRAME);
            fill_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            hand_reg   <= hand_next;
            fill_reg   <= fill_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid        = ovalid_reg;
    assign frame            = frame_reg;
    assign evicted          = ev_reg;
    assign writeback_needed = wb_reg;
    assign victim_owner     = vown_reg;
    assign victim_page      = vpage_reg;
    assign status           = st_reg;

endmodule

// ----- sv/pfa_checker.sv -----
module pfa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [10:0] frame,
    input logic        evicted,
    input logic        writeback_needed,
    input logic [7:0]  victim_owner,
    input logic [10:0] victim_page,
    input logic        status
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame) && $stable(evicted))
        else $error("result changed while stalled");

    a_wb: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && writeback_needed |-> evicted)
        else $error("writeback without eviction");

    a_noev: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted |-> victim_owner == 8'd0 && victim_page == 11'd0)
        else $error("victim fields without eviction");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> !evicted && !writeback_needed)
        else $error("rejected request evicted a frame");

endmodule

bind page_frame_allocator_clock_core pfa_checker u_pfa_checker (.*);
